@@ rtl/kmsl_pkg.sv @@
`default_nettype none

package kmsl_pkg;

    // Default geometry of the key matrix and the LED multiplex
    localparam int DEF_ROWS         = 4;
    localparam int DEF_COLS         = 7;
    localparam int DEF_LED_BITS_ROW = 4;

    // Fixed field widths on the ports
    localparam int SAMPLE_W   = 7;
    localparam int LED_W      = 16;
    localparam int DRIVE_W    = 16;
    localparam int ROW_OUT_W  = 2;
    localparam int KEY_OUT_W  = 28;

    // Drive word layout: LED bits repeated in both shift register bytes
    localparam int HI_NIBBLE_POS = 12;
    localparam int LO_NIBBLE_POS = 4;

    // Per-key sample history
    localparam int               HIST_W        = 3;
    localparam logic [HIST_W-1:0] HIST_ALL_ONE  = 3'b111;
    localparam logic [HIST_W-1:0] HIST_ALL_ZERO = 3'b000;

endpackage

`default_nettype wire

@@ rtl/kmsl_hist_mem.sv @@
`default_nettype none

// Per-row sample history store: one entry per row, one read a cycle with
// registered data, one write a cycle. A row never written reads as zero.
module kmsl_hist_mem #(
    parameter int ROWS = kmsl_pkg::DEF_ROWS,
    parameter int COLS = kmsl_pkg::DEF_COLS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 rd_en,
    input  wire logic [$clog2(ROWS)-1:0]              rd_addr,
    output logic      [COLS*kmsl_pkg::HIST_W-1:0]     rd_data,
    input  wire logic                                 wr_en,
    input  wire logic [$clog2(ROWS)-1:0]              wr_addr,
    input  wire logic [COLS*kmsl_pkg::HIST_W-1:0]     wr_data
);

    localparam int ENTRY_W = COLS * kmsl_pkg::HIST_W;

    logic [ENTRY_W-1:0] mem [ROWS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ROWS-1:0]    written_reg;
    logic               rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Mark rows as written; an unwritten row stands for all-zero history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_written_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

@@ rtl/kmsl_row_update.sv @@
`default_nettype none

// Debounce one row: shift each column bit into its history, then set the
// key on all ones, clear it on all zeros, hold it otherwise.
module kmsl_row_update #(
    parameter int COLS = kmsl_pkg::DEF_COLS
) (
    input  wire logic [kmsl_pkg::SAMPLE_W-1:0]        sample,
    input  wire logic [COLS*kmsl_pkg::HIST_W-1:0]     hist_cur,
    input  wire logic [COLS-1:0]                      stable_cur,
    output logic      [COLS*kmsl_pkg::HIST_W-1:0]     hist_new,
    output logic      [COLS-1:0]                      stable_new
);

    localparam int HW = kmsl_pkg::HIST_W;

    for (genvar c = 0; c < COLS; c++)
    begin : g_col
        logic          bit_in;
        logic [HW-1:0] h_old;
        logic [HW-1:0] h_new;

        // Columns beyond the sample width read as zero
        if (c < kmsl_pkg::SAMPLE_W)
        begin : g_live
            assign bit_in = sample[c];
        end
        else
        begin : g_dead
            assign bit_in = 1'b0;
        end

        assign h_old = hist_cur[c*HW +: HW];
        assign h_new = {h_old[HW-2:0], bit_in};
        assign hist_new[c*HW +: HW] = h_new;

        assign stable_new[c] = (h_new == kmsl_pkg::HIST_ALL_ONE)  ? 1'b1 :
                               (h_new == kmsl_pkg::HIST_ALL_ZERO) ? 1'b0 :
                                                                    stable_cur[c];
    end

endmodule

`default_nettype wire

@@ rtl/key_matrix_scan_led_mux_debounce_unit.sv @@
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        in         in_valid / in_ready    column_sample[6:0]
// out       out        out_valid / out_ready  drive_word[15:0], row_index[1:0],
//                                             key_states[27:0]
// cfg       in         cfg_valid / cfg_ready  led_pattern[15:0]
//
// One item per clock sustained unless the output stalls. Acceptance issues
// the history read for the current row; in the update stage the row is
// debounced, written back and the result registered in the output register.
// Consecutive items always address different rows, so the single read port
// and single write port never collide. Reset clears the row counter, the
// debounced keys, the LED register and the per-row written marks; no
// clearing pass is needed. A stalled output holds the update stage, which in
// turn drops in_ready. cfg_ready is always high.
module key_matrix_scan_led_mux_debounce_unit #(
    parameter int ROWS             = kmsl_pkg::DEF_ROWS,
    parameter int COLS             = kmsl_pkg::DEF_COLS,
    parameter int LED_BITS_PER_ROW = kmsl_pkg::DEF_LED_BITS_ROW
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [kmsl_pkg::SAMPLE_W-1:0]     column_sample,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [kmsl_pkg::DRIVE_W-1:0]      drive_word,
    output logic      [kmsl_pkg::ROW_OUT_W-1:0]    row_index,
    output logic      [kmsl_pkg::KEY_OUT_W-1:0]    key_states,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [kmsl_pkg::LED_W-1:0]        led_pattern
);

    localparam int RW       = $clog2(ROWS);
    localparam int KEYS     = ROWS * COLS;
    localparam int ENTRY_W  = COLS * kmsl_pkg::HIST_W;
    localparam int LED_EXT  = kmsl_pkg::LED_W + ROWS * LED_BITS_PER_ROW;
    localparam int KEY_EXT  = KEYS + kmsl_pkg::KEY_OUT_W;
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    // Configuration
    logic [kmsl_pkg::LED_W-1:0] led_reg;

    // Row counter and update stage
    logic [RW-1:0]               scan_row_reg;
    logic [RW-1:0]               scan_row_next;
    logic                        s1_valid_reg;
    logic [RW-1:0]               s1_row_reg;
    logic [kmsl_pkg::SAMPLE_W-1:0] s1_sample_reg;
    logic [KEYS-1:0]             stable_reg;
    logic [KEYS-1:0]             stable_next;

    // Output register
    logic                        out_valid_reg;
    logic [kmsl_pkg::DRIVE_W-1:0]   drive_reg;
    logic [kmsl_pkg::ROW_OUT_W-1:0] row_out_reg;
    logic [kmsl_pkg::KEY_OUT_W-1:0] keys_out_reg;
    logic [kmsl_pkg::DRIVE_W-1:0]   drive_next;
    logic [kmsl_pkg::KEY_OUT_W-1:0] keys_out_next;

    logic                        in_fire;
    logic                        s1_adv;
    logic [ENTRY_W-1:0]          hist_rd;
    logic [ENTRY_W-1:0]          hist_wr;
    logic [COLS-1:0]             row_stable_new;
    logic [LED_EXT-1:0]          led_ext;
    logic [LED_BITS_PER_ROW-1:0] row_leds;
    logic [KEY_EXT-1:0]          key_ext;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid & in_ready;
    assign s1_adv    = s1_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready  = ~s1_valid_reg | s1_adv;

    assign out_valid  = out_valid_reg;
    assign drive_word = drive_reg;
    assign row_index  = row_out_reg;
    assign key_states = keys_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_reg <= '0;
        end
        else if (cfg_valid)
        begin
            led_reg <= led_pattern;
        end
    end

    // Advance the scanned row modulo ROWS
    assign scan_row_next = (scan_row_reg == LAST_ROW) ? '0 : scan_row_reg + RW'(1);

    kmsl_hist_mem #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_hist_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (scan_row_reg),
        .rd_data (hist_rd),
        .wr_en   (s1_adv),
        .wr_addr (s1_row_reg),
        .wr_data (hist_wr)
    );

    kmsl_row_update #(
        .COLS (COLS)
    ) u_row_update (
        .sample     (s1_sample_reg),
        .hist_cur   (hist_rd),
        .stable_cur (stable_reg[s1_row_reg*COLS +: COLS]),
        .hist_new   (hist_wr),
        .stable_new (row_stable_new)
    );

    // Merge the updated row into the debounced key vector
    always_comb
    begin
        stable_next = stable_reg;
        stable_next[s1_row_reg*COLS +: COLS] = row_stable_new;
    end

    // LED bits for the row; rows whose field lies past the register read zero
    assign led_ext  = {{(LED_EXT - kmsl_pkg::LED_W){1'b0}}, led_reg};
    assign row_leds = led_ext[s1_row_reg*LED_BITS_PER_ROW +: LED_BITS_PER_ROW];

    always_comb
    begin
        drive_next = (kmsl_pkg::DRIVE_W'(row_leds) << kmsl_pkg::HI_NIBBLE_POS)
                   | (kmsl_pkg::DRIVE_W'(row_leds) << kmsl_pkg::LO_NIBBLE_POS)
                   | (kmsl_pkg::DRIVE_W'(1) << s1_row_reg);
    end

    // Keys past the output width are debounced but not reported
    assign key_ext       = {{kmsl_pkg::KEY_OUT_W{1'b0}}, stable_next};
    assign keys_out_next = key_ext[kmsl_pkg::KEY_OUT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_row_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            stable_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                scan_row_reg <= scan_row_next;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                stable_reg <= stable_next;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_row_reg    <= scan_row_reg;
            s1_sample_reg <= column_sample;
        end
        if (s1_adv)
        begin
            drive_reg    <= drive_next;
            row_out_reg  <= kmsl_pkg::ROW_OUT_W'(s1_row_reg);
            keys_out_reg <= keys_out_next;
        end
    end

    // An accepted item reaches the update stage next cycle
    a_fire_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted item did not reach the update stage");

    // A finished update is offered on the output next cycle
    a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("update stage result lost");

    // Consecutive items always address different history rows
    a_row_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> scan_row_reg != $past(scan_row_reg))
        else $error("row counter did not advance");

    // The row counter stays within the matrix
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_row_reg <= LAST_ROW)
        else $error("row counter out of range");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles of quiet (no item moving on any channel) before the run is declared hung
    localparam int QUIET_LIMIT  = 2000;
    localparam int ITEMS_PHASE  = 240;
    localparam int DIRECTED_CNT = 26;

    typedef struct packed {
        logic [kmsl_pkg::DRIVE_W-1:0]   drive;
        logic [kmsl_pkg::ROW_OUT_W-1:0] row;
        logic [kmsl_pkg::KEY_OUT_W-1:0] keys;
    } scan_result_t;

    // One row of the directed table: LED setting to hold, the column sample, and,
    // where it can be read straight off, the scan result to expect
    typedef struct packed {
        logic [kmsl_pkg::LED_W-1:0]     led;
        logic [kmsl_pkg::SAMPLE_W-1:0]  sample;
        logic                           typed;
        logic [kmsl_pkg::DRIVE_W-1:0]   drive;
        logic [kmsl_pkg::ROW_OUT_W-1:0] row;
        logic [kmsl_pkg::KEY_OUT_W-1:0] keys;
    } directed_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [kmsl_pkg::SAMPLE_W-1:0]  column_sample;
    logic                           out_valid;
    logic                           out_ready;
    logic [kmsl_pkg::DRIVE_W-1:0]   drive_word;
    logic [kmsl_pkg::ROW_OUT_W-1:0] row_index;
    logic [kmsl_pkg::KEY_OUT_W-1:0] key_states;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [kmsl_pkg::LED_W-1:0]     led_pattern;

    // Typed expectation travels with the item, driven alongside the payload
    logic                           typed_check;
    scan_result_t                   typed_result;

    // Predictor state: a private copy of the scanner and its LED register
    logic [1:0]                     scan_row_q;
    logic [kmsl_pkg::HIST_W-1:0]    key_hist [kmsl_pkg::DEF_ROWS*kmsl_pkg::DEF_COLS];
    logic [kmsl_pkg::KEY_OUT_W-1:0] debounced_q;
    logic [kmsl_pkg::LED_W-1:0]     led_copy;

    scan_result_t                   pending_scans [$];

    // Stimulus state
    int                             idle_pct;
    int                             stall_pct;
    logic [1:0]                     gen_row;
    logic [kmsl_pkg::KEY_OUT_W-1:0] held_keys;
    logic [kmsl_pkg::LED_W-1:0]     led_now;

    int                             mismatches;
    int                             scans_checked;
    int                             led_writes;
    int                             quiet_cycles;

    directed_row_t directed_rows [DIRECTED_CNT] = '{
        // reset LED value of zero: only the one-hot row select shows
        '{16'h0000, 7'h7F, 1'b1, 16'h0001, 2'd0, 28'h0000000},
        '{16'h0000, 7'h7F, 1'b1, 16'h0002, 2'd1, 28'h0000000},
        '{16'h0000, 7'h7F, 1'b1, 16'h0004, 2'd2, 28'h0000000},
        '{16'h0000, 7'h7F, 1'b1, 16'h0008, 2'd3, 28'h0000000},
        // all LEDs on; second pass, histories only at 011
        '{16'hFFFF, 7'h7F, 1'b1, 16'hF0F1, 2'd0, 28'h0000000},
        '{16'hFFFF, 7'h7F, 1'b1, 16'hF0F2, 2'd1, 28'h0000000},
        '{16'hFFFF, 7'h7F, 1'b1, 16'hF0F4, 2'd2, 28'h0000000},
        '{16'hFFFF, 7'h7F, 1'b1, 16'hF0F8, 2'd3, 28'h0000000},
        // third pass: each row reads 111 and every key presses in turn
        '{16'hFFFF, 7'h7F, 1'b1, 16'hF0F1, 2'd0, 28'h000007F},
        '{16'hFFFF, 7'h7F, 1'b1, 16'hF0F2, 2'd1, 28'h0003FFF},
        '{16'hFFFF, 7'h7F, 1'b1, 16'hF0F4, 2'd2, 28'h01FFFFF},
        '{16'hFFFF, 7'h7F, 1'b1, 16'hF0F8, 2'd3, 28'hFFFFFFF},
        // release: hold through 110 and 100, drop at 000
        '{16'h8421, 7'h00, 1'b0, 16'h0000, 2'd0, 28'h0000000},
        '{16'h8421, 7'h00, 1'b0, 16'h0000, 2'd0, 28'h0000000},
        '{16'h8421, 7'h00, 1'b0, 16'h0000, 2'd0, 28'h0000000},
        '{16'h8421, 7'h00, 1'b0, 16'h0000, 2'd0, 28'h0000000},
        '{16'h8421, 7'h00, 1'b0, 16'h0000, 2'd0, 28'h0000000},
        '{16'h8421, 7'h00, 1'b0, 16'h0000, 2'd0, 28'h0000000},
        '{16'h8421, 7'h00, 1'b0, 16'h0000, 2'd0, 28'h0000000},
        '{16'h8421, 7'h00, 1'b0, 16'h0000, 2'd0, 28'h0000000},
        '{16'h8421, 7'h00, 1'b0, 16'h0000, 2'd0, 28'h0000000},
        '{16'h8421, 7'h00, 1'b0, 16'h0000, 2'd0, 28'h0000000},
        '{16'h8421, 7'h00, 1'b0, 16'h0000, 2'd0, 28'h0000000},
        '{16'h8421, 7'h00, 1'b0, 16'h0000, 2'd0, 28'h0000000},
        // bouncing columns: mixed histories must hold the released state
        '{16'h1234, 7'h55, 1'b0, 16'h0000, 2'd0, 28'h0000000},
        '{16'h1234, 7'h2A, 1'b0, 16'h0000, 2'd0, 28'h0000000}
    };

    key_matrix_scan_led_mux_debounce_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .column_sample (column_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drive_word    (drive_word),
        .row_index     (row_index),
        .key_states    (key_states),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .led_pattern   (led_pattern)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One scan tick of the predictor: build the drive word from this row's LED
    // nibble, shift the samples into the row's histories, settle each key, and
    // advance the row
    function automatic scan_result_t scan_tick(input logic [kmsl_pkg::SAMPLE_W-1:0] cols);
        scan_result_t                res;
        logic [3:0]                  nib;
        logic [kmsl_pkg::HIST_W-1:0] h;
        int                          k;
        nib = led_copy[scan_row_q*kmsl_pkg::DEF_LED_BITS_ROW +: kmsl_pkg::DEF_LED_BITS_ROW];
        res.drive = (kmsl_pkg::DRIVE_W'(nib) << kmsl_pkg::HI_NIBBLE_POS)
                  | (kmsl_pkg::DRIVE_W'(nib) << kmsl_pkg::LO_NIBBLE_POS)
                  | (kmsl_pkg::DRIVE_W'(1) << scan_row_q);
        for (int c = 0; c < kmsl_pkg::DEF_COLS; c++)
        begin
            k = scan_row_q * kmsl_pkg::DEF_COLS + c;
            h = {key_hist[k][kmsl_pkg::HIST_W-2:0], cols[c]};
            key_hist[k] = h;
            if (h == kmsl_pkg::HIST_ALL_ONE)
                debounced_q[k] = 1'b1;
            else if (h == kmsl_pkg::HIST_ALL_ZERO)
                debounced_q[k] = 1'b0;
        end
        res.row  = scan_row_q;
        res.keys = debounced_q;
        scan_row_q = scan_row_q + 2'd1;
        return res;
    endfunction

    // Receiver: refuse output at the phase's stall rate, chosen afresh each cycle
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // Observe every handshake: check results against the oldest expectation,
    // track LED writes, and predict each accepted item
    always @(posedge clk)
    begin
        scan_result_t want;
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;

        if (rst_n && out_valid && out_ready)
        begin
            if (pending_scans.size() == 0)
            begin
                $error("unexpected scan result: drive_word %h row_index %0d key_states %h",
                       drive_word, row_index, key_states);
                mismatches++;
            end
            else
            begin
                want = pending_scans.pop_front();
                scans_checked++;
                if (drive_word !== want.drive)
                begin
                    $error("drive_word: expected %h, got %h", want.drive, drive_word);
                    mismatches++;
                end
                if (row_index !== want.row)
                begin
                    $error("row_index: expected %0d, got %0d", want.row, row_index);
                    mismatches++;
                end
                if (key_states !== want.keys)
                begin
                    $error("key_states: expected %h, got %h", want.keys, key_states);
                    mismatches++;
                end
            end
        end

        if (rst_n && cfg_valid && cfg_ready)
            led_copy = led_pattern;

        if (rst_n && in_valid && in_ready)
        begin
            want = scan_tick(column_sample);
            // Keep the predictor stepping, but hold the row to its typed value
            if (typed_check)
                want = typed_result;
            pending_scans.push_back(want);
        end
    end

    // Offer one item, idling first at the phase's rate, and hold it until taken
    task automatic send_sample(input logic [kmsl_pkg::SAMPLE_W-1:0] cols, input logic typed,
                               input scan_result_t res);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        column_sample <= cols;
        typed_check   <= typed;
        typed_result  <= res;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gen_row = gen_row + 2'd1;
    endtask

    // Withdraw the sender and wait until every predicted scan has come back
    task automatic drain_scans();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_scans.size() != 0)
            @(posedge clk);
    endtask

    // Write the LED register with the block idle
    task automatic program_leds(input logic [kmsl_pkg::LED_W-1:0] value);
        drain_scans();
        repeat (4) @(posedge clk);
        cfg_valid   <= 1'b1;
        led_pattern <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        led_now    = value;
        led_writes++;
    endtask

    // Build a random sample for the row about to be scanned: mostly the
    // intended key positions, sometimes a bounce, occasionally pure noise
    function automatic logic [kmsl_pkg::SAMPLE_W-1:0] pick_sample();
        logic [kmsl_pkg::SAMPLE_W-1:0] cols;
        if ($urandom_range(99) < 8)
            held_keys[gen_row*kmsl_pkg::DEF_COLS
                      + $urandom_range(kmsl_pkg::DEF_COLS-1)] ^= 1'b1;
        cols = held_keys[gen_row*kmsl_pkg::DEF_COLS +: kmsl_pkg::DEF_COLS];
        if ($urandom_range(99) < 15)
            cols ^= kmsl_pkg::SAMPLE_W'(1) << $urandom_range(kmsl_pkg::SAMPLE_W-1);
        if ($urandom_range(99) < 3)
            cols = kmsl_pkg::SAMPLE_W'($urandom_range(127));
        return cols;
    endfunction

    // Hang detector: end the run if nothing moves for too long
    initial
    begin
        @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        scan_result_t               res;
        logic [kmsl_pkg::LED_W-1:0] phase_leds [4];
        int                         phase_idle [4];
        int                         phase_stall [4];

        // Drive every input to a known value and hold reset
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        column_sample <= '0;
        out_ready     <= 1'b0;
        cfg_valid     <= 1'b0;
        led_pattern   <= '0;
        typed_check   <= 1'b0;
        typed_result  <= '0;
        idle_pct      = 0;
        stall_pct     = 0;
        gen_row       = 2'd0;
        held_keys     = '0;
        led_now       = '0;
        led_copy      = '0;
        scan_row_q    = 2'd0;
        debounced_q   = '0;
        foreach (key_hist[i])
            key_hist[i] = kmsl_pkg::HIST_ALL_ZERO;
        mismatches    = 0;
        scans_checked = 0;
        led_writes    = 0;
        quiet_cycles  = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at full rate; rewrite the LEDs whenever a row asks for a new value
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].led != led_now)
                program_leds(directed_rows[i].led);
            res.drive = directed_rows[i].drive;
            res.row   = directed_rows[i].row;
            res.keys  = directed_rows[i].keys;
            send_sample(directed_rows[i].sample, directed_rows[i].typed, res);
        end

        // Random phases, each with its own LED setting and pacing
        phase_leds  = '{16'hFFFF, 16'h0000, kmsl_pkg::LED_W'($urandom),
                        kmsl_pkg::LED_W'($urandom)};
        phase_idle  = '{0, 54, 0, 38};
        phase_stall = '{0, 0, 54, 38};
        for (int p = 0; p < 4; p++)
        begin
            program_leds(phase_leds[p]);
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            for (int n = 0; n < ITEMS_PHASE; n++)
            begin
                // Halfway through the stalled phase, let the pipeline run dry
                if (p == 2 && n == ITEMS_PHASE / 2)
                    drain_scans();
                send_sample(pick_sample(), 1'b0, '0);
            end
        end

        drain_scans();
        idle_pct  = 0;
        stall_pct = 0;
        repeat (8) @(posedge clk);

        $display("Checked %0d scan results across %0d LED register writes,",
                 scans_checked, led_writes);
        $display("with bounce, press and release sequences under four pacing mixes.");
        if (mismatches == 0 && pending_scans.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/kmsl_pkg.sv
rtl/kmsl_hist_mem.sv
rtl/kmsl_row_update.sv
rtl/key_matrix_scan_led_mux_debounce_unit.sv
bench/tb.sv
